// File: rtl/mavg_pkg.sv
// shared types and constants for the moving-average level meter
// no dependencies; imported by mavg_ring and moving_average_level_meter_core
package mavg_pkg;

  // window and sample geometry
  localparam int unsigned WindowLog2 = 4;
  localparam int unsigned SampleBits = 10;
  localparam int unsigned WindowSize = 1 << WindowLog2;
  localparam int unsigned SumBits    = SampleBits + WindowLog2;
  localparam int unsigned RegBits    = 10;
  localparam int unsigned LevelBits  = 3;
  localparam int unsigned LampBits   = 5;

  typedef logic [SampleBits-1:0] sample_t;
  typedef logic [WindowLog2-1:0] pos_t;
  typedef logic [SumBits-1:0]    sum_t;
  typedef logic [RegBits-1:0]    thr_t;
  typedef logic [LevelBits-1:0]  level_t;

  // configuration register indexes
  localparam logic [1:0] RegThrOne   = 2'd0;
  localparam logic [1:0] RegThrTwo   = 2'd1;
  localparam logic [1:0] RegThrThree = 2'd2;
  localparam logic [1:0] RegThrFour  = 2'd3;

  // threshold reset values
  localparam thr_t ThrOneRst   = 10'd200;
  localparam thr_t ThrTwoRst   = 10'd400;
  localparam thr_t ThrThreeRst = 10'd600;
  localparam thr_t ThrFourRst  = 10'd800;

  // level codes
  localparam level_t LevelZero  = 3'd0;
  localparam level_t LevelOne   = 3'd1;
  localparam level_t LevelTwo   = 3'd2;
  localparam level_t LevelThree = 3'd3;
  localparam level_t LevelFour  = 3'd4;

  // write-and-read request into the sample ring
  typedef struct packed {
    logic    we;
    pos_t    addr;
    sample_t wdata;
  } ring_req_t;

endpackage

// File: rtl/moving_average_level_meter_core.sv
// top level of the moving-average level meter: ring access, running sum, banding
// depends on mavg_pkg and mavg_ring
//
// channel   direction  handshake                    payload
// s_axis    in         s_axis_tvalid/s_axis_tready  tdata[9:0] sample
// m_axis    out        m_axis_tvalid/m_axis_tready  tdata[9:0] average, [12:10] level,
//                                                   [17:13] lamp_pattern
// cfg       in         cfg_we_i                     cfg_index_i, cfg_data_i
//
// one word per cycle while the output is not stalled; a word passes from input to output
// through the ring memory read (read-first, same cycle as the write of the new sample)
// and then through the sum update, compare and output register.
// after reset the ring reads as zero through its valid bits; no clearing pass.
// each stage holds while the one after it is full and stalled; an empty stage
// takes a new word even while a result waits at the output.
module moving_average_level_meter_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // slave side
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [15:0]           s_axis_tdata,   // [9:0] sample
  // master side
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [23:0]           m_axis_tdata,   // [9:0] average, [12:10] level, [17:13] lamp
  // configuration
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_index_i,
  input  mavg_pkg::thr_t        cfg_data_i
);
  import mavg_pkg::*;

  thr_t      thr_one_q, thr_two_q, thr_three_q, thr_four_q;
  logic      s1_valid_q;
  sample_t   s1_sample_q;
  sample_t   old_sample;
  sum_t      sum_q, sum_d;
  pos_t      wpos_q;
  logic      out_valid_q;
  sample_t   avg_q;
  level_t    level_q;
  logic [LampBits-1:0] lamp_q;
  sample_t   avg_d;
  level_t    level_d;
  logic      in_fire, out_free, s1_move;
  ring_req_t ring_req;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_one_q   <= ThrOneRst;
      thr_two_q   <= ThrTwoRst;
      thr_three_q <= ThrThreeRst;
      thr_four_q  <= ThrFourRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegThrOne:   thr_one_q   <= cfg_data_i;
        RegThrTwo:   thr_two_q   <= cfg_data_i;
        RegThrThree: thr_three_q <= cfg_data_i;
        RegThrFour:  thr_four_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // handshake and stage movement
  assign out_free      = !out_valid_q || m_axis_tready;
  assign s1_move       = s1_valid_q && out_free;
  assign s_axis_tready = !s1_valid_q || out_free;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // ring access: write new sample, read the one it replaces
  assign ring_req.we    = in_fire;
  assign ring_req.addr  = wpos_q;
  assign ring_req.wdata = s_axis_tdata[SampleBits-1:0];

  mavg_ring u_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (ring_req),
    .rdata_o (old_sample)
  );

  // first stage: write position and sample held for the sum update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      wpos_q     <= '0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
        wpos_q     <= wpos_q + pos_t'(1);
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_sample_q <= s_axis_tdata[SampleBits-1:0];
    end
  end

  // running sum and banding
  assign sum_d = sum_q + sum_t'(s1_sample_q) - sum_t'(old_sample);
  assign avg_d = sum_d[SumBits-1:WindowLog2];

  always_comb begin
    if (avg_d <= thr_one_q) begin
      level_d = LevelZero;
    end else if (avg_d <= thr_two_q) begin
      level_d = LevelOne;
    end else if (avg_d <= thr_three_q) begin
      level_d = LevelTwo;
    end else if (avg_d <= thr_four_q) begin
      level_d = LevelThree;
    end else begin
      level_d = LevelFour;
    end
  end

  // sum register and output word valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_move) begin
        sum_q       <= sum_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      avg_q   <= avg_d;
      level_q <= level_d;
      lamp_q  <= LampBits'(1) << level_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, lamp_q, level_q, avg_q};

endmodule

// File: rtl/mavg_ring.sv
// sample ring: synchronous memory with read-first access and per-entry valid bits
// depends on mavg_pkg
module mavg_ring (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mavg_pkg::ring_req_t req_i,
  output mavg_pkg::sample_t   rdata_o
);
  import mavg_pkg::*;

  sample_t                 mem [WindowSize];
  sample_t                 rd_raw_q;
  logic [WindowSize-1:0]   valid_q;
  logic                    rd_valid_q;

  // storage: old entry is read out in the same cycle it is overwritten
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      rd_raw_q          <= mem[req_i.addr];
      mem[req_i.addr]   <= req_i.wdata;
    end
  end

  // valid bits: an entry never written reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else if (req_i.we) begin
      rd_valid_q           <= valid_q[req_i.addr];
      valid_q[req_i.addr]  <= 1'b1;
    end
  end

  assign rdata_o = rd_valid_q ? rd_raw_q : '0;

endmodule
